// ===== rtl/mls_pkg.sv =====
// ----------------------------------------------------------------------------
// mls_pkg: message letter sequencer package
// types, codes and the character to display position mapping
// ----------------------------------------------------------------------------
package mls_pkg;

    localparam int MSG_LEN_DEF = 16;

    localparam int CFG_W  = 16;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 6;
    localparam int IDX_W  = 4;
    localparam int PH_W   = 2;
    localparam int ACT_W  = 2;

    localparam logic [CFG_W-1:0] PRE_BLANK_RST = 16'd550;
    localparam logic [CFG_W-1:0] SHOW_RST      = 16'd500;
    localparam logic [CFG_W-1:0] GAP_RST       = 16'd50;

    // register indexes
    localparam logic [1:0] REG_PRE_BLANK = 2'd0;
    localparam logic [1:0] REG_SHOW      = 2'd1;
    localparam logic [1:0] REG_GAP       = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_COMMIT = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        PH_PRE  = 3'b001,
        PH_SHOW = 3'b010,
        PH_GAP  = 3'b100
    } t_phase;

    localparam logic [PH_W-1:0] PH_CODE_PRE  = 2'd0;
    localparam logic [PH_W-1:0] PH_CODE_SHOW = 2'd1;
    localparam logic [PH_W-1:0] PH_CODE_GAP  = 2'd2;

    // strobes from the sequencer to the message buffers
    typedef struct packed {
        logic              wr_en;
        logic              commit;
        logic              cur_load;
        logic [CHAR_W-1:0] wr_val;
    } t_buf_ctl;

    function automatic logic [PH_W-1:0] phase_code(input t_phase ph);
        logic [PH_W-1:0] c;
        case (ph)
            PH_PRE:  c = PH_CODE_PRE;
            PH_SHOW: c = PH_CODE_SHOW;
            PH_GAP:  c = PH_CODE_GAP;
            default: c = PH_CODE_PRE;
        endcase
        return c;
    endfunction

    function automatic logic [POS_W-1:0] letter_code(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] lc;
        logic [POS_W-1:0]  code;
        lc = ch;
        if (ch inside {[8'h41:8'h5A]}) lc = ch | 8'h20;
        if (lc inside {[8'h61:8'h7A]}) begin
            code = POS_W'(lc - 8'h60);
        end else begin
            case (lc)
                8'h21:   code = 6'd27;
                8'h3F:   code = 6'd28;
                8'h2D:   code = 6'd29;
                8'h2E:   code = 6'd30;
                8'h2C:   code = 6'd31;
                8'h3A:   code = 6'd32;
                8'h3B:   code = 6'd33;
                8'h27:   code = 6'd34;
                8'h20:   code = 6'd35;
                default: code = '0;
            endcase
        end
        return code;
    endfunction

endpackage

// ===== rtl/mls_msg_buf.sv =====
// ----------------------------------------------------------------------------
// mls_msg_buf: pending and active message buffers
// pending written one character at a time, copied to active on commit
// ----------------------------------------------------------------------------
module mls_msg_buf #(
    parameter int MSG_LEN = mls_pkg::MSG_LEN_DEF,
    parameter int LW      = $clog2(MSG_LEN)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mls_pkg::t_buf_ctl          i_ctl,
    input  logic [LW-1:0]              i_wr_idx,
    input  logic [LW-1:0]              i_rd_idx,
    output logic [mls_pkg::CHAR_W-1:0] o_rd_char,
    output logic [mls_pkg::CHAR_W-1:0] o_next_cur
);
    import mls_pkg::*;

    logic [CHAR_W-1:0] r_pend [MSG_LEN];
    logic [CHAR_W-1:0] r_act  [MSG_LEN];
    logic [CHAR_W-1:0] r_cur;
    logic [CHAR_W-1:0] n_cur;

    assign o_rd_char = r_act[i_rd_idx];

    // character at the letter chosen after the update
    always_comb begin
        n_cur = r_cur;
        if (i_ctl.cur_load) begin
            if (i_ctl.commit)           n_cur = r_pend[0];
            else if (o_rd_char == '0)   n_cur = r_act[0];
            else                        n_cur = o_rd_char;
        end
    end

    assign o_next_cur = n_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MSG_LEN; i++) begin
                r_pend[i] <= '0;
                r_act[i]  <= '0;
            end
            r_cur <= '0;
        end else begin
            r_cur <= n_cur;
            if (i_ctl.wr_en) r_pend[i_wr_idx] <= i_ctl.wr_val;
            if (i_ctl.commit) begin
                for (int i = 0; i < MSG_LEN; i++) r_act[i] <= r_pend[i];
            end
        end
    end

endmodule

// ===== rtl/mls_seq_core.sv =====
// ----------------------------------------------------------------------------
// mls_seq_core: phase sequencer and tick timer
// config registers, phase state, letter index and result computation
// ----------------------------------------------------------------------------
module mls_seq_core #(
    parameter int MSG_LEN = mls_pkg::MSG_LEN_DEF,
    parameter int LW      = $clog2(MSG_LEN)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [mls_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_adv,
    input  logic [mls_pkg::ACT_W-1:0]  i_action,
    input  logic [mls_pkg::IDX_W-1:0]  i_char_index,
    input  logic [mls_pkg::CHAR_W-1:0] i_char_value,
    input  logic [mls_pkg::CHAR_W-1:0] i_rd_char,
    input  logic [mls_pkg::CHAR_W-1:0] i_next_cur,
    output mls_pkg::t_buf_ctl          o_ctl,
    output logic [LW-1:0]              o_wr_idx,
    output logic [LW-1:0]              o_rd_idx,
    output logic [mls_pkg::POS_W-1:0]  o_position,
    output logic [mls_pkg::IDX_W-1:0]  o_letter_index,
    output logic [mls_pkg::PH_W-1:0]   o_phase
);
    import mls_pkg::*;

    logic [CFG_W-1:0] r_pre_blank, r_show, r_gap;
    t_phase           r_phase, n_phase;
    logic [LW-1:0]    r_letter, n_letter;
    logic [CFG_W-1:0] r_tick, n_tick;
    logic             r_pv, n_pv;

    logic [CFG_W-1:0] tick1, len;
    logic             ph_end, wrap;
    logic [LW-1:0]    lnext;
    logic [LW+3:0]    idx_ext;

    assign idx_ext  = {{LW{1'b0}}, i_char_index};
    assign o_wr_idx = idx_ext[LW-1:0];
    assign tick1    = r_tick + 16'd1;
    assign wrap     = (r_letter == LW'(MSG_LEN - 1));
    assign lnext    = wrap ? '0 : r_letter + LW'(1);
    assign o_rd_idx = lnext;

    always_comb begin
        case (r_phase)
            PH_PRE:  len = r_pre_blank;
            PH_SHOW: len = r_show;
            default: len = r_gap;
        endcase
    end

    assign ph_end = (tick1 >= len) || (tick1 == '0);

    always_comb begin
        n_phase      = r_phase;
        n_letter     = r_letter;
        n_tick       = r_tick;
        n_pv         = r_pv;
        o_ctl.wr_en    = 1'b0;
        o_ctl.commit   = 1'b0;
        o_ctl.cur_load = 1'b0;
        o_ctl.wr_val   = i_char_value;
        if (i_adv) begin
            case (t_action'(i_action))
                ACT_TICK: begin
                    n_tick = ph_end ? '0 : tick1;
                    if (ph_end) begin
                        case (r_phase)
                            PH_PRE:  n_phase = PH_SHOW;
                            PH_SHOW: n_phase = PH_GAP;
                            default: begin
                                o_ctl.cur_load = 1'b1;
                                o_ctl.commit   = r_pv;
                                n_pv           = 1'b0;
                                if (r_pv || wrap || i_rd_char == '0) begin
                                    n_letter = '0;
                                    n_phase  = PH_PRE;
                                end else begin
                                    n_letter = lnext;
                                    n_phase  = PH_SHOW;
                                end
                            end
                        endcase
                    end
                end
                ACT_WRITE: begin
                    o_ctl.wr_en = (idx_ext < (LW+4)'(MSG_LEN));
                end
                ACT_COMMIT: begin
                    n_pv = 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_position     = (n_phase == PH_SHOW) ? letter_code(i_next_cur) : '0;
    assign o_letter_index = IDX_W'({{IDX_W{1'b0}}, n_letter});
    assign o_phase        = phase_code(n_phase);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_blank <= PRE_BLANK_RST;
            r_show      <= SHOW_RST;
            r_gap       <= GAP_RST;
            r_phase     <= PH_PRE;
            r_letter    <= '0;
            r_tick      <= '0;
            r_pv        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PRE_BLANK: r_pre_blank <= i_cfg_data;
                    REG_SHOW:      r_show      <= i_cfg_data;
                    REG_GAP:       r_gap       <= i_cfg_data;
                    default: ;
                endcase
            end
            r_phase  <= n_phase;
            r_letter <= n_letter;
            r_tick   <= n_tick;
            r_pv     <= n_pv;
        end
    end

    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_letter <= LW'(MSG_LEN - 1))
        else $error("letter index beyond message length");

    a_pre_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PRE |-> r_letter == '0)
        else $error("blank pre-phase away from first letter");

    a_commit_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_action == ACT_COMMIT |=> r_pv)
        else $error("commit not recorded");

    a_boundary_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.commit |=> !r_pv && r_letter == '0 && r_phase == PH_PRE)
        else $error("commit at boundary did not restart");

endmodule

// ===== rtl/message_letter_sequencer_top.sv =====
// a word is held in the input register, then its result word is registered in the result register
// throughput: one word per cycle while the output is not stalled, limited by the single state update stage
// a stalled output holds its result and lets the input register fill
// reset (synchronous, i_rst_n low) clears both message buffers, the pending
// flag, letter index and timer, and loads the default phase durations
// ----------------------------------------------------------------------------
// message_letter_sequencer_top: message letter sequencer
// input register, sequencer update and result register on stream ports
// ----------------------------------------------------------------------------
module message_letter_sequencer_top #(
    parameter int MSG_LEN = mls_pkg::MSG_LEN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [mls_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // action[1:0], char_index[5:2], char_value[13:6], zero pad
    input  logic [15:0]               i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // position[5:0], letter_index[9:6], phase[11:10], zero pad
    output logic [15:0]               o_m_axis_tdata
);
    import mls_pkg::*;

    localparam int LW = $clog2(MSG_LEN);

    logic              r_in_valid;
    logic [13:0]       r_in;
    logic              r_res_valid;
    logic [11:0]       r_res;
    logic              adv;

    t_buf_ctl          ctl;
    logic [LW-1:0]     wr_idx, rd_idx;
    logic [CHAR_W-1:0] rd_char, next_cur;
    logic [POS_W-1:0]  position;
    logic [IDX_W-1:0]  letter_index;
    logic [PH_W-1:0]   phase;

    assign adv             = r_in_valid && (!r_res_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign o_m_axis_tvalid = r_res_valid;
    assign o_m_axis_tdata  = {4'b0, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) r_in_valid <= i_s_axis_tvalid;
            if (adv)                  r_res_valid <= 1'b1;
            else if (i_m_axis_tready) r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) r_in <= i_s_axis_tdata[13:0];
        if (adv) r_res <= {phase, letter_index, position};
    end

    mls_seq_core #(
        .MSG_LEN (MSG_LEN),
        .LW      (LW)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_adv          (adv),
        .i_action       (r_in[1:0]),
        .i_char_index   (r_in[5:2]),
        .i_char_value   (r_in[13:6]),
        .i_rd_char      (rd_char),
        .i_next_cur     (next_cur),
        .o_ctl          (ctl),
        .o_wr_idx       (wr_idx),
        .o_rd_idx       (rd_idx),
        .o_position     (position),
        .o_letter_index (letter_index),
        .o_phase        (phase)
    );

    mls_msg_buf #(
        .MSG_LEN (MSG_LEN),
        .LW      (LW)
    ) u_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_wr_idx   (wr_idx),
        .i_rd_idx   (rd_idx),
        .o_rd_char  (rd_char),
        .o_next_cur (next_cur)
    );

endmodule

// ===== tb/sv/message_letter_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// message_letter_sequencer_top_tb: self-checking bench for the letter sequencer
// a directed table of ticks, writes, commits and register writes, then random
// messages, ticks and noise under several duration settings, with every output
// word checked against a fixed expectation or an in-bench model of the sequencer
// ----------------------------------------------------------------------------
module message_letter_sequencer_top_tb;
    import mls_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0]       REG_UNUSED = 2'd3;
    localparam int LATENCY      = 2;
    localparam int SETTLE       = LATENCY + 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 650;
    localparam int RUN_PHASES   = 6;
    localparam int MAX_LINES    = 60;

    // output word layout, lowest bits last
    typedef struct packed {
        logic [3:0]       pad;
        logic [PH_W-1:0]  phase;
        logic [IDX_W-1:0] letter;
        logic [POS_W-1:0] pos;
    } t_display;

    typedef struct packed {
        logic              cfg;
        logic [1:0]        code;
        logic [3:0]        idx;
        logic [CFG_W-1:0]  data;
        logic              typed;
        t_display          want;
    } t_step;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [15:0]       i_s_axis_tdata;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [15:0]       o_m_axis_tdata;

    // model state
    logic [CFG_W-1:0]  dur_pre, dur_show, dur_gap;
    logic [7:0]        active_msg [16];
    logic [7:0]        pending_msg [16];
    logic              commit_armed;
    logic [IDX_W-1:0]  cur_letter;
    logic [PH_W-1:0]   cur_phase;
    logic [15:0]       tick_cnt;

    t_display          display_q [$];
    t_step             plan [$];
    logic [7:0]        punct [9] = '{8'h21, 8'h3F, 8'h2D, 8'h2E, 8'h2C,
                                     8'h3A, 8'h3B, 8'h27, 8'h20};
    int                errors = 0;
    int                lines = 0;
    int                items_sent = 0;
    int                cycles = 0;
    logic              calm = 1'b0;

    message_letter_sequencer_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= calm || ($urandom_range(0, 99) >= 24);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL message_letter_sequencer_top");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (lines < MAX_LINES) begin
            $display("mismatch at %0t: %s", $realtime, msg);
            lines++;
        end
    endtask

    function automatic logic [POS_W-1:0] glyph_of(input logic [7:0] ch);
        logic [7:0]       c;
        logic [POS_W-1:0] g;
        c = (ch >= 8'h41 && ch <= 8'h5A) ? (ch | 8'h20) : ch;
        if (c >= 8'h61 && c <= 8'h7A) begin
            g = POS_W'(c - 8'h60);
        end else begin
            case (c)
                8'h21:   g = 6'd27;
                8'h3F:   g = 6'd28;
                8'h2D:   g = 6'd29;
                8'h2E:   g = 6'd30;
                8'h2C:   g = 6'd31;
                8'h3A:   g = 6'd32;
                8'h3B:   g = 6'd33;
                8'h27:   g = 6'd34;
                8'h20:   g = 6'd35;
                default: g = '0;
            endcase
        end
        return g;
    endfunction

    function automatic t_display predict_display(input logic [1:0] act,
                                                 input logic [3:0] idx,
                                                 input logic [7:0] val);
        t_display         d;
        logic [CFG_W-1:0] span;
        d = '0;
        case (act)
            ACT_TICK: begin
                span = (cur_phase == PH_CODE_PRE)  ? dur_pre :
                       (cur_phase == PH_CODE_SHOW) ? dur_show : dur_gap;
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= span || tick_cnt == '0) begin
                    tick_cnt = '0;
                    if (cur_phase == PH_CODE_PRE) begin
                        cur_phase = PH_CODE_SHOW;
                    end else if (cur_phase == PH_CODE_SHOW) begin
                        cur_phase = PH_CODE_GAP;
                    end else begin
                        // letter boundary
                        cur_letter = cur_letter + 1'b1;
                        if (commit_armed) begin
                            active_msg   = pending_msg;
                            commit_armed = 1'b0;
                            cur_letter   = '0;
                        end
                        if (active_msg[cur_letter] == 8'h00) cur_letter = '0;
                        cur_phase = (cur_letter == '0) ? PH_CODE_PRE : PH_CODE_SHOW;
                    end
                end
            end
            ACT_WRITE:  pending_msg[idx] = val;
            ACT_COMMIT: commit_armed = 1'b1;
            default: ;
        endcase
        d.letter = cur_letter;
        d.phase  = cur_phase;
        if (cur_phase == PH_CODE_SHOW) d.pos = glyph_of(active_msg[cur_letter]);
        return d;
    endfunction

    always @(posedge i_clk) begin
        t_display got;
        t_display want;
        got = o_m_axis_tdata;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (display_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", o_m_axis_tdata));
            end else begin
                want = display_q.pop_front();
                if (got.pos !== want.pos)
                    report_mismatch($sformatf("position %0d, want %0d", got.pos, want.pos));
                if (got.letter !== want.letter)
                    report_mismatch($sformatf("letter %0d, want %0d", got.letter, want.letter));
                if (got.phase !== want.phase)
                    report_mismatch($sformatf("phase %0d, want %0d", got.phase, want.phase));
                if (got.pad !== want.pad)
                    report_mismatch($sformatf("pad bits %b not zero", got.pad));
            end
        end
    end

    task automatic send_word(input logic [1:0] act, input logic [3:0] idx,
                             input logic [7:0] val, input logic typed,
                             input t_display want);
        t_display d;
        if (!calm) begin
            while ($urandom_range(0, 99) < 24) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, val, idx, act};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        d = predict_display(act, idx, val);
        display_q.push_back(typed ? want : d);
        items_sent++;
    endtask

    task automatic send_item(input logic [1:0] act, input logic [3:0] idx,
                             input logic [7:0] val);
        send_word(act, idx, val, 1'b0, '0);
    endtask

    // registers change only once the sequencer has drained
    task automatic write_register(input logic [1:0] regi, input logic [CFG_W-1:0] value);
        i_s_axis_tvalid <= 1'b0;
        while (display_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= regi;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (regi)
            REG_PRE_BLANK: dur_pre  = value;
            REG_SHOW:      dur_show = value;
            REG_GAP:       dur_gap  = value;
            default: ;
        endcase
    endtask

    function automatic void plan_item(input logic [1:0] act, input logic [3:0] idx,
                                      input logic [7:0] val);
        plan.push_back('{1'b0, act, idx, CFG_W'(val), 1'b0, '0});
    endfunction

    function automatic void plan_checked(input logic [1:0] act, input logic [3:0] idx,
                                         input logic [7:0] val, input t_display want);
        plan.push_back('{1'b0, act, idx, CFG_W'(val), 1'b1, want});
    endfunction

    function automatic void plan_register(input logic [1:0] regi,
                                          input logic [CFG_W-1:0] value);
        plan.push_back('{1'b1, regi, 4'd0, value, 1'b0, '0});
    endfunction

    initial begin
        t_display idle_blank;
        int       ph;
        int       start;
        int       len;
        int       n;
        int       left;
        logic [7:0] ch;

        idle_blank = {4'd0, PH_CODE_PRE, 4'd0, 6'd0};
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;

        dur_pre      = PRE_BLANK_RST;
        dur_show     = SHOW_RST;
        dur_gap      = GAP_RST;
        commit_armed = 1'b0;
        cur_letter   = '0;
        cur_phase    = PH_CODE_PRE;
        tick_cnt     = '0;
        for (int i = 0; i < 16; i++) begin
            active_msg[i]  = 8'h00;
            pending_msg[i] = 8'h00;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset durations keep everything in the opening blank
        plan_checked(ACT_UNUSED, 4'd0,  8'h00, idle_blank);
        plan_checked(ACT_TICK,   4'd0,  8'h00, idle_blank);
        plan_checked(ACT_WRITE,  4'd0,  8'h48, idle_blank);
        plan_checked(ACT_WRITE,  4'd1,  8'h69, idle_blank);
        plan_checked(ACT_WRITE,  4'd2,  8'h21, idle_blank);
        plan_checked(ACT_WRITE,  4'd15, 8'hFF, idle_blank);
        plan_checked(ACT_COMMIT, 4'd0,  8'h00, idle_blank);
        plan_register(REG_PRE_BLANK, 16'd1);
        plan_register(REG_SHOW,      16'd1);
        plan_register(REG_GAP,       16'd1);
        // walk the committed message up to its terminating nul
        repeat (9) plan_item(ACT_TICK, 4'd0, 8'h00);
        plan_checked(ACT_TICK, 4'd0, 8'h00, idle_blank);
        // extremes, zero duration and unknown register
        plan_register(REG_UNUSED,    16'hFFFF);
        plan_register(REG_PRE_BLANK, 16'hFFFF);
        plan_register(REG_SHOW,      16'd0);
        plan_register(REG_GAP,       16'hFFFF);
        plan_item(ACT_TICK, 4'd15, 8'hFF);
        plan_item(ACT_TICK, 4'd0,  8'h00);
        // duration lowered below the running count
        plan_register(REG_PRE_BLANK, 16'd1);
        plan_checked(ACT_TICK, 4'd0, 8'h00, {4'd0, PH_CODE_SHOW, 4'd0, 6'd8});
        plan_item(ACT_TICK,   4'd0,  8'h00);
        plan_item(ACT_WRITE,  4'd0,  8'h00);
        plan_item(ACT_COMMIT, 4'd0,  8'h00);
        plan_item(ACT_UNUSED, 4'd15, 8'hFF);

        foreach (plan[k]) begin
            if (plan[k].cfg) write_register(plan[k].code, plan[k].data);
            else send_word(plan[k].code, plan[k].idx, plan[k].data[7:0],
                           plan[k].typed, plan[k].want);
        end

        for (ph = 0; ph < RUN_PHASES; ph++) begin
            calm = (ph == 3);
            if (ph == 0) begin
                write_register(REG_PRE_BLANK, 16'd1);
                write_register(REG_SHOW,      16'd1);
                write_register(REG_GAP,       16'd1);
            end else if (ph == 1) begin
                write_register(REG_PRE_BLANK, 16'd0);
                write_register(REG_SHOW,      16'd0);
                write_register(REG_GAP,       16'd0);
            end else begin
                write_register(REG_PRE_BLANK, ($urandom_range(0, 3) == 0) ?
                               CFG_W'($urandom_range(5, 12)) : CFG_W'($urandom_range(1, 4)));
                write_register(REG_SHOW, ($urandom_range(0, 3) == 0) ?
                               CFG_W'($urandom_range(5, 12)) : CFG_W'($urandom_range(1, 4)));
                write_register(REG_GAP, ($urandom_range(0, 3) == 0) ?
                               CFG_W'($urandom_range(5, 12)) : CFG_W'($urandom_range(1, 4)));
                if (ph == 2) write_register(REG_UNUSED, CFG_W'($urandom));
            end
            start = items_sent;
            while (items_sent < start + RANDOM_ITEMS / RUN_PHASES) begin
                if ($urandom_range(0, 99) < 80) begin
                    // a message, its commit and a run of ticks
                    len = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(0, 8);
                    for (int k = 0; k < len; k++) begin
                        case ($urandom_range(0, 2))
                            0:       ch = (8'h41 + 8'($urandom_range(0, 25)))
                                          | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
                            1:       ch = punct[$urandom_range(0, 8)];
                            default: ch = 8'($urandom_range(1, 255));
                        endcase
                        send_item(ACT_WRITE, 4'(k), ch);
                    end
                    if (len < 16) send_item(ACT_WRITE, 4'(len), 8'h00);
                    if ($urandom_range(0, 9) != 0)
                        send_item(ACT_COMMIT, 4'($urandom), 8'($urandom));
                    if ($urandom_range(0, 9) == 0)
                        send_item(ACT_WRITE, 4'($urandom), 8'($urandom));
                    n = (len == 16) ? $urandom_range(40, 120) : $urandom_range(4, 30);
                    // keep the tick run within what is left of this phase, but at least four ticks
                    left = start + RANDOM_ITEMS / RUN_PHASES - items_sent;
                    if (n > left) n = (left > 4) ? left : 4;
                    repeat (n) send_item(ACT_TICK, 4'($urandom), 8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_item(2'($urandom), 4'($urandom), 8'($urandom));
                end
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (display_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS message_letter_sequencer_top");
        end else begin
            $display("FAIL message_letter_sequencer_top");
        end
        $finish;
    end

endmodule
